// ----- src/iolm_pkg.sv -----
// ----------------------------------------------------------------------------
// iolm_pkg
// Shared types and constants for the I/O latency threshold monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iolm_pkg;

  localparam int TID_W  = 22;
  localparam int PID_W  = 22;
  localparam int TIME_W = 64;
  localparam int FILE_W = 64;
  localparam int OFF_W  = 63;
  localparam int OP_W   = 2;
  localparam int SIZE_W = 64;
  localparam int LAT_W  = 55;
  localparam int CFG_W  = 64;

  localparam int CFG_INDEX_W = 1;

  localparam int NS_PER_US   = 1000;
  localparam int REM_W       = 10;
  localparam int DIV_CHUNK_W = 16;
  localparam int DIV_STEPS   = TIME_W / DIV_CHUNK_W;
  localparam int DIV_PART_W  = REM_W + DIV_CHUNK_W;

  // A partial dividend below 2^26 times DIV_RECIP, shifted right by DIV_SHIFT,
  // gives its exact quotient by 1000.
  localparam int               RECIP_W   = 27;
  localparam int               DIV_SHIFT = 36;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd68719477;

  localparam logic MODE_ENTRY = 1'b0;
  localparam logic MODE_EXIT  = 1'b1;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_OPEN  = 2'd2;
  localparam logic [OP_W-1:0] OP_SYNC  = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_PROCESS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_LATENCY    = 1'd1;

  typedef struct packed {
    logic             valid;
    logic [TID_W-1:0] tid;
  } tag_t;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [OFF_W-1:0]  start_offset;
    logic [OFF_W-1:0]  end_offset;
    logic [FILE_W-1:0] file;
  } record_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- src/iolm_ram.sv -----
// ----------------------------------------------------------------------------
// iolm_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iolm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/iolm_div.sv -----
// ----------------------------------------------------------------------------
// iolm_div
// Divider of a 64-bit value by 1000, sixteen quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iolm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [iolm_pkg::TIME_W-1:0] dividend,
  output logic                       done,
  output logic [iolm_pkg::LAT_W-1:0]  quotient
);

  import iolm_pkg::*;

  localparam int CNT_W  = $clog2(DIV_STEPS);
  localparam int PROD_W = DIV_PART_W + RECIP_W;
  localparam logic [CNT_W-1:0]      LAST_STEP = CNT_W'(DIV_STEPS - 1);
  localparam logic [DIV_PART_W-1:0] DIVISOR   = DIV_PART_W'(NS_PER_US);

  logic                   busy;
  logic [CNT_W-1:0]       step_cnt;
  logic [TIME_W-1:0]      work;
  logic [REM_W-1:0]       rem;
  logic [DIV_PART_W-1:0]  part;
  logic [PROD_W-1:0]      prod;
  logic [DIV_CHUNK_W-1:0] part_q;
  logic [DIV_PART_W-1:0]  part_back;
  logic [REM_W-1:0]       rem_next;

  always_comb begin
    part      = {rem, work[TIME_W-1 -: DIV_CHUNK_W]};
    prod      = PROD_W'(part) * PROD_W'(DIV_RECIP);
    part_q    = prod[DIV_SHIFT +: DIV_CHUNK_W];
    part_back = DIV_PART_W'(part_q) * DIVISOR;
    rem_next  = REM_W'(part - part_back);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
        work     <= dividend;
        rem      <= '0;
      end else if (busy) begin
        work     <= {work[TIME_W-DIV_CHUNK_W-1:0], part_q};
        rem      <= rem_next;
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = work[LAT_W-1:0];

endmodule

`default_nettype wire

// ----- src/io_latency_threshold_monitor.sv -----
// ----------------------------------------------------------------------------
// io_latency_threshold_monitor
// Per-thread file operation latency tracker with a reporting threshold.
//
// Entry transactions record a start time, offsets and a file id per thread
// in a table held in two memories (tags and records). Exit transactions look
// up and free the thread's record and report the operation when the elapsed
// time exceeds min_latency_ns. Both data channels use valid/ready; the
// configuration port is a plain write port, written only while idle by the
// user; the block itself does not enforce this. After reset the block sweeps
// the tag memory to clear it, with in_ready low. An item that is filtered out
// is taken without leaving the idle state. Otherwise the table is scanned
// one slot per cycle through the tag memory read port: a match ends the scan
// at its slot, a miss once the last slot has been checked. A reported exit
// passes through the threshold compare, the four-step divide by 1000 in the
// divide state and the load of the output register. The result waits in
// the output register while out_ready is low and the next input is taken
// meanwhile; a second result then waits until the register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module io_latency_threshold_monitor #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic [iolm_pkg::TID_W-1:0]        thread_id,
  input  logic [iolm_pkg::PID_W-1:0]        process_id,
  input  logic [iolm_pkg::TIME_W-1:0]       time_ns,
  input  logic [iolm_pkg::FILE_W-1:0]       file_id,
  input  logic [iolm_pkg::OFF_W-1:0]        start_offset,
  input  logic [iolm_pkg::OFF_W-1:0]        end_offset,
  input  logic [iolm_pkg::OP_W-1:0]         operation,
  input  logic signed [iolm_pkg::SIZE_W-1:0] return_size,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [iolm_pkg::LAT_W-1:0]        latency_us,
  output logic [iolm_pkg::TIME_W-1:0]       finish_time_ns,
  output logic [iolm_pkg::OFF_W-1:0]        offset,
  output logic signed [iolm_pkg::SIZE_W-1:0] byte_count,
  output logic [iolm_pkg::PID_W-1:0]        owner_process,
  output logic [iolm_pkg::OP_W-1:0]         op_kind,
  output logic [iolm_pkg::FILE_W-1:0]       file_handle,
  input  logic                              cfg_wr_en,
  input  logic [iolm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [iolm_pkg::CFG_W-1:0]        cfg_data
);

  import iolm_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t state;
  state_t state_next;

  logic [PID_W-1:0]  target_process;
  logic [TIME_W-1:0] min_latency_ns;

  logic                     cur_mode;
  logic [TID_W-1:0]         cur_thread;
  logic [PID_W-1:0]         cur_process;
  logic [TIME_W-1:0]        cur_time;
  logic [FILE_W-1:0]        cur_file;
  logic [OFF_W-1:0]         cur_start_offset;
  logic [OFF_W-1:0]         cur_end_offset;
  logic [OP_W-1:0]          cur_operation;
  logic signed [SIZE_W-1:0] cur_return_size;

  logic [IDX_W-1:0] clr_idx;
  logic [CNT_W-1:0] issue_cnt;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  record_t          rec;

  logic             tag_we;
  logic             data_we;
  logic [IDX_W-1:0] wr_addr;
  tag_t             tag_wdata;
  record_t          data_wdata;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  tag_t             tag_rdata;
  record_t          data_rdata;

  logic              accept;
  logic              pass;
  logic              drop;
  logic              hit;
  logic              cur_free;
  logic [IDX_W-1:0]  free_sel;
  logic [TIME_W-1:0] delta;
  logic              div_start;
  logic              div_done;
  logic [LAT_W-1:0]  div_quotient;
  logic              out_load;

  iolm_ram #(
    .WIDTH($bits(tag_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .waddr(wr_addr),
    .wdata(tag_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(tag_rdata)
  );

  iolm_ram #(
    .WIDTH($bits(record_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_data_ram (
    .clk  (clk),
    .we   (data_we),
    .waddr(wr_addr),
    .wdata(data_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(data_rdata)
  );

  iolm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(delta),
    .done    (div_done),
    .quotient(div_quotient)
  );

  assign accept   = in_valid && in_ready;
  assign pass     = (target_process == '0) || (target_process == process_id);
  assign drop     = !pass || ((mode == MODE_ENTRY) && (file_id == '0));
  assign hit      = chk_vld && tag_rdata.valid && (tag_rdata.tid == cur_thread);
  assign cur_free = !tag_rdata.valid;
  assign free_sel = free_found ? free_idx : chk_idx;
  assign delta    = cur_time - rec.start_time;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    tag_we     = 1'b0;
    data_we    = 1'b0;
    wr_addr    = chk_idx;
    tag_wdata  = '{valid: 1'b1, tid: cur_thread};
    data_wdata = '{start_time: cur_time, start_offset: cur_start_offset,
                   end_offset: cur_end_offset, file: cur_file};
    rd_en      = 1'b0;
    rd_addr    = issue_cnt[IDX_W-1:0];
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        tag_we    = 1'b1;
        wr_addr   = clr_idx;
        tag_wdata = '{valid: 1'b0, tid: '0};
        if (clr_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !drop) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = (issue_cnt != SCAN_END);
        if (hit) begin
          tag_we = 1'b1;
          if (cur_mode == MODE_ENTRY) begin
            data_we    = 1'b1;
            state_next = ST_IDLE;
          end else begin
            tag_wdata  = '{valid: 1'b0, tid: cur_thread};
            state_next = ST_CALC;
          end
        end else if (chk_vld && (chk_idx == LAST_IDX)) begin
          if ((cur_mode == MODE_ENTRY) && (free_found || cur_free)) begin
            tag_we  = 1'b1;
            data_we = 1'b1;
            wr_addr = free_sel;
          end
          state_next = ST_IDLE;
        end
      end
      ST_CALC: begin
        if (delta > min_latency_ns) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_process <= '0;
      min_latency_ns <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TARGET_PROCESS: target_process <= cfg_data[PID_W-1:0];
        REG_MIN_LATENCY:    min_latency_ns <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      issue_cnt  <= '0;
      chk_vld    <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (accept) begin
        issue_cnt  <= '0;
        chk_vld    <= 1'b0;
        free_found <= 1'b0;
      end else if (state == ST_SCAN) begin
        chk_vld <= rd_en;
        if (rd_en) begin
          issue_cnt <= issue_cnt + 1'b1;
        end
        if (chk_vld && cur_free && !free_found) begin
          free_found <= 1'b1;
        end
      end else begin
        chk_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mode         <= mode;
      cur_thread       <= thread_id;
      cur_process      <= process_id;
      cur_time         <= time_ns;
      cur_file         <= file_id;
      cur_start_offset <= start_offset;
      cur_end_offset   <= end_offset;
      cur_operation    <= operation;
      cur_return_size  <= return_size;
    end
    if (state == ST_SCAN) begin
      chk_idx <= rd_addr;
      if (chk_vld && cur_free && !free_found) begin
        free_idx <= chk_idx;
      end
      if (hit) begin
        rec <= data_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      latency_us     <= div_quotient;
      finish_time_ns <= cur_time;
      offset         <= rec.start_offset;
      owner_process  <= cur_process;
      op_kind        <= cur_operation;
      file_handle    <= rec.file;
      if (cur_operation == OP_SYNC) begin
        byte_count <= signed'({1'b0, rec.end_offset} - {1'b0, rec.start_offset});
      end else begin
        byte_count <= cur_return_size;
      end
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside of the divide state");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue_cnt <= SCAN_END))
    else $error("scan issued reads past the end of the table");

  a_chk_idx_range: assert property (@(posedge clk) disable iff (rst)
    (chk_vld && (state == ST_SCAN)) |-> (chk_idx <= LAST_IDX))
    else $error("scan checked a slot outside of the table");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result appeared without passing through the emit state");

endmodule

`default_nettype wire

// ----- verif/tb_io_latency_threshold_monitor.sv -----
// ----------------------------------------------------------------------------
// tb_io_latency_threshold_monitor
// Self-checking testbench for the I/O latency threshold monitor.
//
// Entry and exit transactions are driven on the input channel. A scoreboard
// keeps its own copy of the per-thread tracking table and the two filter
// registers, and predicts the latency report, if any, for each accepted exit. Reports
// are checked field by field in order. A short directed sequence covers the
// field extremes, every operation, record overwrite, ignored entries, exits
// with no record and elapsed-time wraparound. A table-fill pass then drives
// the table past full. Random phases follow under several register settings
// and sender/receiver idle patterns, mostly paired entry/exit traffic on a
// small thread pool with some stray items mixed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_io_latency_threshold_monitor;
  import iolm_pkg::*;

  localparam int SLOTS        = 256;
  localparam int POOL_N       = 16;
  localparam int PHASE_ITEMS  = 110;
  localparam int FILL_THREADS = 264;
  localparam int QUIET_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int SHOWN_ERRORS = 10;

  localparam logic [TID_W-1:0]  FILL_BASE = 22'h200000;
  localparam logic [TIME_W-1:0] NS_PER_US_W = TIME_W'(NS_PER_US);
  localparam logic [63:0]       MAX64 = '1;
  localparam logic [OFF_W-1:0]  MAX_OFF = '1;
  localparam logic [TID_W-1:0]  MAX_TID = '1;
  localparam logic [PID_W-1:0]  MAX_PID = '1;
  localparam logic [SIZE_W-1:0] MIN_SIZE = {1'b1, {(SIZE_W-1){1'b0}}};
  localparam logic [SIZE_W-1:0] MAX_SIZE = {1'b0, {(SIZE_W-1){1'b1}}};

  typedef struct packed {
    logic                     mode;
    logic [TID_W-1:0]         tid;
    logic [PID_W-1:0]         pid;
    logic [TIME_W-1:0]        time_ns;
    logic [FILE_W-1:0]        file;
    logic [OFF_W-1:0]         soff;
    logic [OFF_W-1:0]         eoff;
    logic [OP_W-1:0]          op;
    logic signed [SIZE_W-1:0] rsize;
  } io_event_t;

  typedef struct packed {
    logic [LAT_W-1:0]         latency_us;
    logic [TIME_W-1:0]        finish_ns;
    logic [OFF_W-1:0]         offset;
    logic signed [SIZE_W-1:0] byte_count;
    logic [PID_W-1:0]         owner;
    logic [OP_W-1:0]          op;
    logic [FILE_W-1:0]        file;
  } io_report_t;

  class latency_scoreboard;
    bit                live[SLOTS];
    logic [TID_W-1:0]  owner_tid[SLOTS];
    logic [TIME_W-1:0] start_ns[SLOTS];
    logic [OFF_W-1:0]  first_off[SLOTS];
    logic [OFF_W-1:0]  last_off[SLOTS];
    logic [FILE_W-1:0] handle[SLOTS];
    logic [PID_W-1:0]  pid_filter;
    logic [63:0]       threshold_ns;
    io_report_t        report_q[$];
    int                errors;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      pid_filter = '0;
      threshold_ns = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_TARGET_PROCESS: pid_filter = value[PID_W-1:0];
        REG_MIN_LATENCY: threshold_ns = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return report_q.size();
    endfunction

    function void note_input(io_event_t ev);
      int slot;
      logic [TIME_W-1:0] elapsed;
      io_report_t rep;
      if (pid_filter != '0 && pid_filter != ev.pid) return;
      slot = -1;
      for (int i = 0; i < SLOTS; i++)
        if (slot < 0 && live[i] && owner_tid[i] == ev.tid) slot = i;
      if (ev.mode == MODE_ENTRY) begin
        if (ev.file == '0) return;
        for (int i = 0; i < SLOTS; i++)
          if (slot < 0 && !live[i]) slot = i;
        if (slot < 0) return;
        live[slot] = 1'b1;
        owner_tid[slot] = ev.tid;
        start_ns[slot] = ev.time_ns;
        first_off[slot] = ev.soff;
        last_off[slot] = ev.eoff;
        handle[slot] = ev.file;
        return;
      end
      if (slot < 0) return;
      live[slot] = 1'b0;
      elapsed = ev.time_ns - start_ns[slot];
      if (elapsed <= threshold_ns) return;
      rep.latency_us = LAT_W'(elapsed / NS_PER_US_W);
      rep.finish_ns = ev.time_ns;
      rep.offset = first_off[slot];
      if (ev.op == OP_SYNC) rep.byte_count = {1'b0, last_off[slot]} - {1'b0, first_off[slot]};
      else rep.byte_count = ev.rsize;
      rep.owner = ev.pid;
      rep.op = ev.op;
      rep.file = handle[slot];
      report_q.push_back(rep);
    endfunction

    function string describe(io_report_t r);
      return $sformatf("lat=%0d fin=%h off=%h cnt=%0d pid=%h op=%0d file=%h",
                       r.latency_us, r.finish_ns, r.offset, r.byte_count, r.owner,
                       r.op, r.file);
    endfunction

    function void check_result(io_report_t got);
      io_report_t want;
      string why;
      string want_text;
      why = "";
      want_text = "none";
      if (report_q.size() == 0) begin
        why = " unexpected transaction";
      end else begin
        want = report_q.pop_front();
        want_text = describe(want);
        if (got.latency_us !== want.latency_us) why = {why, " latency_us"};
        if (got.finish_ns !== want.finish_ns) why = {why, " finish_time_ns"};
        if (got.offset !== want.offset) why = {why, " offset"};
        if (got.byte_count !== want.byte_count) why = {why, " byte_count"};
        if (got.owner !== want.owner) why = {why, " owner_process"};
        if (got.op !== want.op) why = {why, " op_kind"};
        if (got.file !== want.file) why = {why, " file_handle"};
      end
      if (why != "") begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("ERROR at %0t:%s\n  expected: %s\n  actual:   %s", $realtime, why,
                   want_text, describe(got));
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      mode;
  logic [TID_W-1:0]          thread_id;
  logic [PID_W-1:0]          process_id;
  logic [TIME_W-1:0]         time_ns;
  logic [FILE_W-1:0]         file_id;
  logic [OFF_W-1:0]          start_offset;
  logic [OFF_W-1:0]          end_offset;
  logic [OP_W-1:0]           operation;
  logic signed [SIZE_W-1:0]  return_size;
  logic                      out_valid;
  logic                      out_ready;
  logic [LAT_W-1:0]          latency_us;
  logic [TIME_W-1:0]         finish_time_ns;
  logic [OFF_W-1:0]          offset;
  logic signed [SIZE_W-1:0]  byte_count;
  logic [PID_W-1:0]          owner_process;
  logic [OP_W-1:0]           op_kind;
  logic [FILE_W-1:0]         file_handle;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]          cfg_data;

  latency_scoreboard sb = new();
  int                gap_pct = 0;
  int                stall_pct = 0;
  int                cycles = 0;
  logic [TID_W-1:0]  tid_pool[POOL_N];
  logic [TIME_W-1:0] pool_start[POOL_N];

  io_latency_threshold_monitor #(.TABLE_ENTRIES(SLOTS)) u_dut (.*);

  always #5 clk = ~clk;

  always @(negedge clk) out_ready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(io_report_t'({latency_us, finish_time_ns, offset, byte_count,
                                    owner_process, op_kind, file_handle}));
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [63:0] random64();
    return {$urandom, $urandom};
  endfunction

  function automatic io_event_t random_event();
    io_event_t ev;
    ev.mode = 1'($urandom);
    ev.tid = TID_W'($urandom);
    ev.pid = PID_W'($urandom);
    ev.time_ns = random64();
    ev.file = random64();
    ev.soff = OFF_W'(random64());
    ev.eoff = OFF_W'(random64());
    ev.op = OP_W'($urandom);
    ev.rsize = random64();
    return ev;
  endfunction

  function automatic logic [63:0] pick_delay(logic [63:0] floor_ns);
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return 64'($urandom_range(5000));
    if (roll < 50) return floor_ns + 64'($urandom_range(2)) - 64'd1;
    if (roll < 80) return floor_ns + 64'($urandom);
    return random64();
  endfunction

  function automatic io_event_t next_event(logic [PID_W-1:0] target, logic [63:0] floor_ns);
    io_event_t ev;
    int k;
    int roll;
    ev = random_event();
    roll = $urandom_range(99);
    if (roll < 12) begin
      if ($urandom_range(1) == 0) ev.file = '0;
      return ev;
    end
    k = $urandom_range(POOL_N - 1);
    ev.tid = tid_pool[k];
    if (target != '0 && roll >= 16) ev.pid = target;
    if (roll < 56) begin
      ev.mode = MODE_ENTRY;
      if (ev.file == '0) ev.file = 64'd1;
      pool_start[k] = ev.time_ns;
    end else begin
      ev.mode = MODE_EXIT;
      ev.time_ns = pool_start[k] + pick_delay(floor_ns);
    end
    return ev;
  endfunction

  task automatic send_event(input io_event_t ev);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    mode = ev.mode;
    thread_id = ev.tid;
    process_id = ev.pid;
    time_ns = ev.time_ns;
    file_id = ev.file;
    start_offset = ev.soff;
    end_offset = ev.eoff;
    operation = ev.op;
    return_size = ev.rsize;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(ev);
    @(negedge clk);
  endtask

  task automatic enter(input logic [TID_W-1:0] tid, input logic [PID_W-1:0] pid,
                       input logic [63:0] t, input logic [63:0] file,
                       input logic [OFF_W-1:0] soff, input logic [OFF_W-1:0] eoff);
    io_event_t ev;
    ev = random_event();
    ev.mode = MODE_ENTRY;
    ev.tid = tid;
    ev.pid = pid;
    ev.time_ns = t;
    ev.file = file;
    ev.soff = soff;
    ev.eoff = eoff;
    send_event(ev);
  endtask

  task automatic leave(input logic [TID_W-1:0] tid, input logic [PID_W-1:0] pid,
                       input logic [63:0] t, input logic [OP_W-1:0] op,
                       input logic [SIZE_W-1:0] rsize);
    io_event_t ev;
    ev = random_event();
    ev.mode = MODE_EXIT;
    ev.tid = tid;
    ev.pid = pid;
    ev.time_ns = t;
    ev.op = op;
    ev.rsize = rsize;
    send_event(ev);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic quiesce();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic run_directed();
    enter('0, '0, '0, 64'd1, '0, MAX_OFF);
    leave('0, '0, '0, OP_READ, '0);
    enter(MAX_TID, MAX_PID, MAX64, MAX64, MAX_OFF, '0);
    leave(MAX_TID, MAX_PID, 64'd999, OP_SYNC, '0);
    enter(22'd5, 22'd3, 64'd100, '0, 63'd1, 63'd2);
    leave(22'd5, 22'd3, 64'd200, OP_WRITE, 64'd7);
    enter(22'd6, 22'd1, 64'd1000, 64'd77, 63'd10, 63'd20);
    leave(22'd6, 22'd1, 64'd1999, OP_READ, MIN_SIZE);
    enter(22'd6, 22'd1, '0, 64'd88, 63'd10, 63'd20);
    leave(22'd6, 22'd1, 64'd1000000, OP_WRITE, MAX_SIZE);
    enter(22'd9, 22'd2, 64'd5000, 64'd99, 63'd300, 63'd100);
    leave(22'd9, 22'd2, 64'd6001, OP_OPEN, MAX64);
    enter(22'd10, 22'd2, 64'd10, 64'd3, '0, MAX_OFF);
    leave(22'd10, 22'd2, 64'd5, OP_SYNC, '0);
    enter(22'd7, 22'd4, 64'd100, 64'd1, 63'd11, 63'd12);
    enter(22'd7, 22'd4, 64'd5000, 64'd2, 63'd21, 63'd22);
    leave(22'd7, 22'd4, 64'd6000, OP_READ, 64'd4096);
    leave(22'd7, 22'd4, 64'd7000, OP_READ, 64'd4096);
  endtask

  task automatic fill_table();
    for (int i = 0; i < FILL_THREADS; i++)
      enter(FILL_BASE + TID_W'(i), PID_W'($urandom), random64(), random64() | 64'd1,
            OFF_W'(random64()), OFF_W'(random64()));
    for (int i = 0; i < FILL_THREADS; i++)
      leave(FILL_BASE + TID_W'(i), PID_W'($urandom), random64(), OP_W'($urandom),
            random64());
  endtask

  task automatic run_phase(input logic [PID_W-1:0] target, input logic [63:0] floor_ns,
                           input int gap, input int stall, input bit hold);
    quiesce();
    write_reg(REG_TARGET_PROCESS, CFG_W'(target));
    write_reg(REG_MIN_LATENCY, floor_ns);
    gap_pct = gap;
    stall_pct = stall;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (hold && n == PHASE_ITEMS / 2) begin
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      send_event(next_event(target, floor_ns));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_ENTRY;
    thread_id = '0;
    process_id = '0;
    time_ns = '0;
    file_id = '0;
    start_offset = '0;
    end_offset = '0;
    operation = OP_READ;
    return_size = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_TARGET_PROCESS;
    cfg_data = '0;
    for (int k = 0; k < POOL_N; k++) begin
      tid_pool[k] = TID_W'($urandom);
      pool_start[k] = '0;
    end
    tid_pool[0] = '0;
    tid_pool[1] = MAX_TID;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    quiesce();
    write_reg(REG_TARGET_PROCESS, '0);
    write_reg(REG_MIN_LATENCY, '0);
    run_directed();
    fill_table();

    run_phase('0, '0, 0, 0, 1'b0);
    run_phase('0, 64'd1000, 74, 0, 1'b0);
    run_phase(PID_W'($urandom | 1), 64'd5000, 0, 74, 1'b0);
    run_phase(MAX_PID, 64'($urandom_range(1 << 20)), 19, 19, 1'b1);
    run_phase('0, MAX64, 0, 0, 1'b0);
    run_phase(PID_W'(1), '0, 74, 0, 1'b0);
    run_phase('0, random64() >> 24, 0, 74, 1'b0);
    run_phase('0, 64'h8000_0000_0000_0000, 19, 19, 1'b0);
    run_phase('0, '0, 0, 74, 1'b1);
    run_phase('0, 64'd123456, 0, 0, 1'b0);

    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
